@@ hw/rtl/psrlt_pkg.sv @@
package psrlt_pkg;

    localparam int TABLE_SIZE_DEF = 8;

    localparam int ADDR_W  = 64;
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 32;

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CFG_W-1:0] MIN_INTERVAL_RST  = 32'd1280;
    localparam logic [CFG_W-1:0] ENTRY_TIMEOUT_RST = 32'd7680;

    typedef enum logic
    {
        CFG_MIN_INTERVAL  = 1'b0,
        CFG_ENTRY_TIMEOUT = 1'b1
    } cfg_index_t;

    typedef enum logic
    {
        KIND_CHECK = 1'b0,
        KIND_SWEEP = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        OUT_KNOWN_ALLOWED = 3'd0,
        OUT_KNOWN_DROPPED = 3'd1,
        OUT_INSERTED      = 3'd2,
        OUT_REPLACED      = 3'd3,
        OUT_NOT_STORED    = 3'd4
    } outcome_t;

    typedef struct packed
    {
        logic     allow;
        outcome_t outcome;
    } res_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_RD,
        ST_EVAL,
        ST_FIN,
        ST_RES,
        ST_SW_RD,
        ST_SW_EVAL,
        ST_CMP_RD,
        ST_CMP_EVAL
    } state_t;

endpackage

@@ hw/rtl/psrlt_mem.sv @@
module psrlt_mem #(
    parameter int DEPTH  = 8,
    parameter int DATA_W = 163
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                     wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                     rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/psrlt_engine.sv @@
module psrlt_engine #(
    parameter int TABLE_SIZE = psrlt_pkg::TABLE_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  psrlt_pkg::kind_t              kind,
    input  logic [psrlt_pkg::ADDR_W-1:0]  addr_high,
    input  logic [psrlt_pkg::ADDR_W-1:0]  addr_low,
    input  logic [psrlt_pkg::STAMP_W-1:0] now_ticks,
    input  logic [psrlt_pkg::CFG_W-1:0]   min_interval,
    input  logic [psrlt_pkg::CFG_W-1:0]   entry_timeout,
    output logic                          idle,
    output logic                          res_valid,
    output psrlt_pkg::res_t               res,
    input  logic                          res_taken
);

    import psrlt_pkg::*;

    localparam int IDX_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
    localparam int WORD_W = 2 * ADDR_W + STAMP_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    // number of freed entries that were older than the given rank
    function automatic logic [IDX_W-1:0] older_freed(
        input logic [TABLE_SIZE-1:0] mask,
        input logic [IDX_W-1:0]      rank
    );
        logic [IDX_W-1:0] n;
        n = '0;
        for (int j = 0; j < TABLE_SIZE; j++)
        begin
            if (mask[j] && (j < int'(rank)))
            begin
                n = n + IDX_W'(1);
            end
        end
        return n;
    endfunction

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [TABLE_SIZE-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TABLE_SIZE-1:0]  freed_reg, freed_next;
    logic                   match_found_reg, match_found_next;
    logic                   free_found_reg, free_found_next;
    logic                   cand_found_reg, cand_found_next;

    // item and walk payload
    kind_t                  kind_reg;
    logic [ADDR_W-1:0]      hi_reg, lo_reg;
    logic [STAMP_W-1:0]     now_reg;
    logic [IDX_W-1:0]       match_idx_reg, match_idx_next;
    logic [STAMP_W-1:0]     match_stamp_reg, match_stamp_next;
    logic [IDX_W-1:0]       match_rank_reg, match_rank_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]       cand_idx_reg, cand_idx_next;
    logic [STAMP_W-1:0]     cand_stamp_reg, cand_stamp_next;
    logic [IDX_W-1:0]       cand_rank_reg, cand_rank_next;
    res_t                   res_reg, res_next;

    logic                   mem_we, mem_re;
    logic [IDX_W-1:0]       mem_waddr;
    logic [WORD_W-1:0]      mem_wdata, mem_rdata;

    logic [IDX_W-1:0]       r_rank;
    logic [STAMP_W-1:0]     r_stamp;
    logic [ADDR_W-1:0]      r_lo, r_hi;
    logic                   r_valid;
    logic                   last;

    assign r_rank  = mem_rdata[IDX_W-1:0];
    assign r_stamp = mem_rdata[IDX_W +: STAMP_W];
    assign r_lo    = mem_rdata[IDX_W + STAMP_W +: ADDR_W];
    assign r_hi    = mem_rdata[IDX_W + STAMP_W + ADDR_W +: ADDR_W];
    assign r_valid = valid_reg[idx_reg];
    assign last    = (idx_reg == LAST_IDX);

    psrlt_mem #(
        .DEPTH  (TABLE_SIZE),
        .DATA_W (WORD_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        valid_next       = valid_reg;
        count_next       = count_reg;
        freed_next       = freed_reg;
        match_found_next = match_found_reg;
        free_found_next  = free_found_reg;
        cand_found_next  = cand_found_reg;
        match_idx_next   = match_idx_reg;
        match_stamp_next = match_stamp_reg;
        match_rank_next  = match_rank_reg;
        free_idx_next    = free_idx_reg;
        cand_idx_next    = cand_idx_reg;
        cand_stamp_next  = cand_stamp_reg;
        cand_rank_next   = cand_rank_reg;
        res_next         = res_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = idx_reg;
        mem_wdata        = mem_rdata;
        res_valid        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    idx_next         = '0;
                    freed_next       = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    cand_found_next  = 1'b0;
                    state_next       = (kind == KIND_SWEEP) ? ST_SW_RD : ST_RD;
                end
            end

            ST_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                if (r_valid && !match_found_reg && r_hi == hi_reg && r_lo == lo_reg)
                begin
                    match_found_next = 1'b1;
                    match_idx_next   = idx_reg;
                    match_stamp_next = r_stamp;
                    match_rank_next  = r_rank;
                end
                if (!r_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                // oldest stamp below now; ties go to the lower rank
                if (r_valid && r_stamp < now_reg &&
                    (!cand_found_reg || r_stamp < cand_stamp_reg ||
                     (r_stamp == cand_stamp_reg && r_rank < cand_rank_reg)))
                begin
                    cand_found_next = 1'b1;
                    cand_idx_next   = idx_reg;
                    cand_stamp_next = r_stamp;
                    cand_rank_next  = r_rank;
                end
                if (last)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_RD;
                end
            end

            ST_FIN:
            begin
                state_next = ST_RES;
                if (match_found_reg)
                begin
                    if ((now_reg - match_stamp_reg) < min_interval)
                    begin
                        res_next = '{allow: 1'b0, outcome: OUT_KNOWN_DROPPED};
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = match_idx_reg;
                        mem_wdata = {hi_reg, lo_reg, now_reg, match_rank_reg};
                        res_next  = '{allow: 1'b1, outcome: OUT_KNOWN_ALLOWED};
                    end
                end
                else if (free_found_reg)
                begin
                    mem_we                   = 1'b1;
                    mem_waddr                = free_idx_reg;
                    mem_wdata                = {hi_reg, lo_reg, now_reg, count_reg[IDX_W-1:0]};
                    valid_next[free_idx_reg] = 1'b1;
                    count_next               = count_reg + CNT_W'(1);
                    res_next                 = '{allow: 1'b1, outcome: OUT_INSERTED};
                end
                else if (cand_found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cand_idx_reg;
                    mem_wdata = {hi_reg, lo_reg, now_reg, cand_rank_reg};
                    res_next  = '{allow: 1'b1, outcome: OUT_REPLACED};
                end
                else
                begin
                    res_next = '{allow: 1'b1, outcome: OUT_NOT_STORED};
                end
            end

            ST_RES:
            begin
                res_valid = 1'b1;
                if (res_taken)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SW_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_SW_EVAL;
            end

            ST_SW_EVAL:
            begin
                if (r_valid && (now_reg - r_stamp) > entry_timeout)
                begin
                    valid_next[idx_reg] = 1'b0;
                    freed_next[r_rank]  = 1'b1;
                    count_next          = count_reg - CNT_W'(1);
                end
                if (last)
                begin
                    idx_next   = '0;
                    state_next = ST_CMP_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_SW_RD;
                end
            end

            ST_CMP_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_CMP_EVAL;
            end

            ST_CMP_EVAL:
            begin
                // close the rank gaps left by freed entries
                if (r_valid)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {r_hi, r_lo, r_stamp,
                                 r_rank - older_freed(freed_reg, r_rank)};
                end
                if (last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_CMP_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            valid_reg       <= '0;
            count_reg       <= '0;
            freed_reg       <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            cand_found_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            valid_reg       <= valid_next;
            count_reg       <= count_next;
            freed_reg       <= freed_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            cand_found_reg  <= cand_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            kind_reg <= kind;
            hi_reg   <= addr_high;
            lo_reg   <= addr_low;
            now_reg  <= now_ticks;
        end
        match_idx_reg   <= match_idx_next;
        match_stamp_reg <= match_stamp_next;
        match_rank_reg  <= match_rank_next;
        free_idx_reg    <= free_idx_next;
        cand_idx_reg    <= cand_idx_next;
        cand_stamp_reg  <= cand_stamp_next;
        cand_rank_reg   <= cand_rank_next;
        res_reg         <= res_next;
    end

    assign idle = (state_reg == ST_IDLE);
    assign res  = res_reg;

    // fill count tracks the valid bits
    a_count_matches_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg))
    ) else $error("fill count out of step with valid bits");

    // table writes only happen at the commit of a check or during rank compaction
    a_write_phase: assert property (
        @(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_FIN || state_reg == ST_CMP_EVAL)
    ) else $error("table write outside commit or compaction");

    // sweep items never reach the result stage
    a_sweep_no_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RES) |-> (kind_reg == KIND_CHECK)
    ) else $error("sweep produced a result");

    // an insert grows the table by exactly one
    a_insert_grows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && !match_found_reg && free_found_reg)
        |=> count_reg == $past(count_reg) + CNT_W'(1)
    ) else $error("insert did not grow the fill count");

endmodule

@@ hw/rtl/per_source_rate_limit_table_top.sv @@
// Check beat: m_axis_tvalid rises once the engine has read and evaluated each table entry
// on the single table read port, committed, and loaded its result stage into the output
// register. The next beat is accepted once the engine is idle again: after a check, its
// result taken; after a sweep, the expire walk plus the rank compaction walk.
// A result held in the full output register stalls the next check in its result stage.
// Reset (rst_n, async, active low) empties the table at once and loads the defaults.
module per_source_rate_limit_table_top #(
    parameter int TABLE_SIZE = psrlt_pkg::TABLE_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [psrlt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // addr_high, addr_low, now_ticks
    input  logic [0:0]                        s_axis_tuser,   // kind
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [psrlt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // allow, outcome, zero pad
    // configuration writes
    input  logic                              cfg_we,
    input  logic [0:0]                        cfg_index,
    input  logic [psrlt_pkg::CFG_W-1:0]       cfg_data
);

    import psrlt_pkg::*;

    logic [CFG_W-1:0]       min_interval_reg;
    logic [CFG_W-1:0]       entry_timeout_reg;

    logic                   eng_idle;
    logic                   eng_res_valid;
    res_t                   eng_res;
    logic                   res_load;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    // Config registers; the user must write them only while the block is quiet; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg  <= MIN_INTERVAL_RST;
            entry_timeout_reg <= ENTRY_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_INTERVAL:  min_interval_reg  <= cfg_data;
                CFG_ENTRY_TIMEOUT: entry_timeout_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // The engine walks the table for one beat at a time.
    assign s_axis_tready = eng_idle;

    psrlt_engine #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (s_axis_tvalid && s_axis_tready),
        .kind          (kind_t'(s_axis_tuser[0])),
        .addr_high     (s_axis_tdata[ADDR_W-1:0]),
        .addr_low      (s_axis_tdata[2*ADDR_W-1:ADDR_W]),
        .now_ticks     (s_axis_tdata[2*ADDR_W +: STAMP_W]),
        .min_interval  (min_interval_reg),
        .entry_timeout (entry_timeout_reg),
        .idle          (eng_idle),
        .res_valid     (eng_res_valid),
        .res           (eng_res),
        .res_taken     (res_load)
    );

    // Output register: frees the engine while a result waits downstream.
    assign res_load = eng_res_valid && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            m_data_reg <= {(OUT_TDATA_W - 4)'(0), eng_res.outcome, eng_res.allow};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

@@ dv/psrlt_checker.sv @@
module psrlt_checker #(
    parameter int TABLE_SIZE = psrlt_pkg::TABLE_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [psrlt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // addr_high, addr_low, now_ticks
    input  logic [0:0]                        s_axis_tuser,   // kind
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [psrlt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // allow, outcome, zero pad
    input  logic                              cfg_we,
    input  logic [0:0]                        cfg_index,
    input  logic [psrlt_pkg::CFG_W-1:0]       cfg_data,
    output int                                pending,
    output int                                fail_count
);

    // shadow of the source table
    logic        slot_used  [TABLE_SIZE];
    logic [63:0] slot_hi    [TABLE_SIZE];
    logic [63:0] slot_lo    [TABLE_SIZE];
    logic [31:0] slot_stamp [TABLE_SIZE];
    int          slot_rank  [TABLE_SIZE];

    logic [31:0] min_gap;
    logic [31:0] max_age;

    psrlt_pkg::res_t verdict_q [$];
    int              errors;

    function automatic psrlt_pkg::res_t rate_decide(input logic [63:0] hi,
                                                    input logic [63:0] lo,
                                                    input logic [31:0] now);
        psrlt_pkg::res_t r;
        logic [31:0]     age;
        int              n_used;
        int              best;
        r.allow   = 1'b1;
        r.outcome = psrlt_pkg::OUT_NOT_STORED;
        n_used    = 0;
        best      = -1;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (slot_used[i] && slot_hi[i] == hi && slot_lo[i] == lo)
            begin
                age = now - slot_stamp[i];
                if (age < min_gap)
                begin
                    r.allow   = 1'b0;
                    r.outcome = psrlt_pkg::OUT_KNOWN_DROPPED;
                end
                else
                begin
                    slot_stamp[i] = now;
                    r.outcome     = psrlt_pkg::OUT_KNOWN_ALLOWED;
                end
                return r;
            end
            if (slot_used[i])
                n_used++;
        end
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (!slot_used[i])
            begin
                slot_used[i]  = 1'b1;
                slot_hi[i]    = hi;
                slot_lo[i]    = lo;
                slot_stamp[i] = now;
                slot_rank[i]  = n_used;
                r.outcome     = psrlt_pkg::OUT_INSERTED;
                return r;
            end
        end
        // table full: oldest stamp strictly below now, earliest insert on a tie
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (slot_stamp[i] < now &&
                (best < 0 || slot_stamp[i] < slot_stamp[best] ||
                 (slot_stamp[i] == slot_stamp[best] && slot_rank[i] < slot_rank[best])))
                best = i;
        end
        if (best >= 0)
        begin
            slot_hi[best]    = hi;
            slot_lo[best]    = lo;
            slot_stamp[best] = now;
            r.outcome        = psrlt_pkg::OUT_REPLACED;
        end
        return r;
    endfunction

    function automatic void expire_entries(input logic [31:0] now);
        logic [31:0] age;
        int          gone;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (slot_used[i])
            begin
                age = now - slot_stamp[i];
                if (age > max_age)
                begin
                    gone         = slot_rank[i];
                    slot_used[i] = 1'b0;
                    for (int j = 0; j < TABLE_SIZE; j++)
                        if (slot_used[j] && slot_rank[j] > gone)
                            slot_rank[j]--;
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        psrlt_pkg::res_t want;
        logic            got_allow;
        logic [2:0]      got_outcome;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                slot_used[i]  = 1'b0;
                slot_hi[i]    = '0;
                slot_lo[i]    = '0;
                slot_stamp[i] = '0;
                slot_rank[i]  = 0;
            end
            min_gap = psrlt_pkg::MIN_INTERVAL_RST;
            max_age = psrlt_pkg::ENTRY_TIMEOUT_RST;
            verdict_q.delete();
            errors     = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    psrlt_pkg::CFG_MIN_INTERVAL:  min_gap = cfg_data;
                    psrlt_pkg::CFG_ENTRY_TIMEOUT: max_age = cfg_data;
                    default: ;
                endcase
            end
            // results first: a result never belongs to a beat taken at the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_allow   = m_axis_tdata[0];
                got_outcome = m_axis_tdata[3:1];
                if (verdict_q.size() == 0)
                begin
                    $error("result beat with nothing outstanding: allow %0d outcome %0d",
                           got_allow, got_outcome);
                    errors++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (got_allow !== want.allow)
                    begin
                        $error("allow: expected %0d, actual %0d", want.allow, got_allow);
                        errors++;
                    end
                    if (got_outcome !== want.outcome)
                    begin
                        $error("outcome: expected %0d, actual %0d", want.outcome, got_outcome);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == psrlt_pkg::KIND_SWEEP)
                    expire_entries(s_axis_tdata[159:128]);
                else
                    verdict_q.push_back(rate_decide(s_axis_tdata[63:0], s_axis_tdata[127:64],
                                                    s_axis_tdata[159:128]));
            end
            pending    <= verdict_q.size();
            fail_count <= errors;
        end
    end

endmodule

@@ dv/tb_per_source_rate_limit_table_top.sv @@
// Testbench for the per-source rate limiter table.
// The top only makes stimulus and reports the verdict; psrlt_checker watches
// both streams and the config port, keeps its own copy of the table and
// compares every result beat in order.
module tb_per_source_rate_limit_table_top;

    localparam int POOL_MAX = 12;

    // ------------------------------------------------------------------
    // clock, reset, DUT pins
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [psrlt_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // addr_high, addr_low, now_ticks
    logic [0:0]                        s_axis_tuser;   // kind
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [psrlt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // allow, outcome, zero pad
    logic                              cfg_we;
    logic [0:0]                        cfg_index;
    logic [psrlt_pkg::CFG_W-1:0]       cfg_data;

    int pending;
    int fail_count;

    // idle / backpressure controls set by the main sequence; rx_idle_on and hold_len also drive the result sink
    bit          tx_idle_on;
    bit          rx_idle_on;
    int unsigned hold_len;

    // source address pool for the random part
    logic [63:0] src_hi [POOL_MAX];
    logic [63:0] src_lo [POOL_MAX];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    per_source_rate_limit_table_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    psrlt_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    // ------------------------------------------------------------------
    // result side: random stall bursts, plus one long hold on request.
    // Exactly one assignment to tready per clock.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left    = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                stall_left = hold_len;
                hold_len   = 0;
            end
            else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 7);
            if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // Offer one beat and return at the edge that takes it. tvalid stays high
    // into the next call unless that call opens with an idle burst.
    task automatic send_beat(input psrlt_pkg::kind_t kind, input logic [63:0] hi,
                             input logic [63:0] lo, input logic [31:0] now);
        int unsigned gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 7);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, lo, hi};
        s_axis_tuser  <= kind;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Drain: all results back, then wait out the length of a sweep so the
    // block is idle even if the last beat was a sweep.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input psrlt_pkg::cfg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random traffic: mostly a pool of 6 to POOL_MAX sources (often more than the table
    // holds, so hits, drops, inserts and replacements all happen), time mostly moving
    // forward in steps scaled to the config, some sweeps, some noise.
    task automatic run_random(input int n, input int unsigned span, input logic [31:0] start,
                              input bit bursty);
        logic [31:0] tick;
        int unsigned npool;
        int unsigned pick;
        int unsigned roll;
        tick  = start;
        npool = $urandom_range(6, POOL_MAX);
        for (int i = 0; i < POOL_MAX; i++)
        begin
            src_hi[i] = {$urandom, $urandom};
            src_lo[i] = {$urandom, $urandom};
        end
        // near misses: one half of the address matches another source
        src_hi[1] = src_hi[0];
        src_lo[2] = src_lo[0];
        for (int k = 0; k < n; k++)
        begin
            if (k % 50 == 0)
            begin
                tx_idle_on = bursty && ($urandom_range(0, 3) != 0);
                rx_idle_on = bursty && ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 31);
            if (roll == 0)
                tick = $urandom;
            else if (roll == 1)
                tick = tick - $urandom_range(0, span);
            else
                tick = tick + $urandom_range(0, span);
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, npool - 1);
            if (roll < 8)
                send_beat(psrlt_pkg::KIND_SWEEP, {$urandom, $urandom}, {$urandom, $urandom},
                          tick);
            else if (roll < 88)
                send_beat(psrlt_pkg::KIND_CHECK, src_hi[pick], src_lo[pick], tick);
            else
                send_beat(psrlt_pkg::KIND_CHECK, {$urandom, $urandom}, {$urandom, $urandom},
                          tick);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        logic [63:0] ones;
        logic [31:0] rnd_gap;
        logic [31:0] rnd_age;
        ones          = '1;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_len      = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, reset config (interval 1280, timeout 7680) ---
        // first sight inserts, too soon drops, exactly one interval later allows
        send_beat(psrlt_pkg::KIND_CHECK, ones, ones, 32'd100);
        send_beat(psrlt_pkg::KIND_CHECK, ones, ones, 32'd200);
        send_beat(psrlt_pkg::KIND_CHECK, ones, ones, 32'd1380);
        send_beat(psrlt_pkg::KIND_CHECK, 64'd0, 64'd0, 32'd0);
        // half-matching addresses are distinct sources
        send_beat(psrlt_pkg::KIND_CHECK, ones, 64'd0, 32'd500);
        send_beat(psrlt_pkg::KIND_CHECK, 64'd0, ones, 32'd500);
        for (int k = 1; k <= 4; k++)
            send_beat(psrlt_pkg::KIND_CHECK, 64'(k) << 60, 64'(k), 32'd2000);
        // table full and nothing older than now: not stored
        send_beat(psrlt_pkg::KIND_CHECK, 64'h5a5a_5a5a_5a5a_5a5a, 64'h1, 32'd0);
        // replace the oldest, then a tie on 500 goes to the earlier insert
        send_beat(psrlt_pkg::KIND_CHECK, 64'h5a5a_5a5a_5a5a_5a5a, 64'h2, 32'd3000);
        send_beat(psrlt_pkg::KIND_CHECK, 64'h5a5a_5a5a_5a5a_5a5a, 64'h3, 32'd3000);
        send_beat(psrlt_pkg::KIND_CHECK, 64'h5a5a_5a5a_5a5a_5a5a, 64'h4, 32'd3000);
        // sweep frees only the first source, ranks close up, address ignored
        send_beat(psrlt_pkg::KIND_SWEEP, ones, 64'd0, 32'd9500);
        send_beat(psrlt_pkg::KIND_CHECK, ones, ones, 32'd9500);
        // sweep at the top of the clock frees everything
        send_beat(psrlt_pkg::KIND_SWEEP, 64'd0, ones, 32'hffff_ffff);
        // interval measured across the wrap
        send_beat(psrlt_pkg::KIND_CHECK, 64'd0, 64'd0, 32'hffff_ff00);
        send_beat(psrlt_pkg::KIND_CHECK, 64'd0, 64'd0, 32'h0000_0100);
        send_beat(psrlt_pkg::KIND_CHECK, 64'd0, 64'd0, 32'h0000_0500);
        // age equal to the timeout is kept
        send_beat(psrlt_pkg::KIND_SWEEP, ones, ones, 32'h0000_0500 + 32'd7680);
        send_beat(psrlt_pkg::KIND_CHECK, 64'd0, 64'd0, 32'h0000_0500 + 32'd7680);
        settle();

        // --- tight config, start just below the wrap, long receiver hold ---
        write_reg(psrlt_pkg::CFG_MIN_INTERVAL, 32'd50);
        write_reg(psrlt_pkg::CFG_ENTRY_TIMEOUT, 32'd400);
        hold_len = 400;
        run_random(320, 80, 32'hffff_f000, 1'b1);
        settle();

        // --- zero interval and zero timeout ---
        write_reg(psrlt_pkg::CFG_MIN_INTERVAL, 32'd0);
        write_reg(psrlt_pkg::CFG_ENTRY_TIMEOUT, 32'd0);
        run_random(320, 1000, $urandom, 1'b1);
        settle();

        // --- both at maximum: known sources nearly always dropped, no expiry ---
        write_reg(psrlt_pkg::CFG_MIN_INTERVAL, 32'hffff_ffff);
        write_reg(psrlt_pkg::CFG_ENTRY_TIMEOUT, 32'hffff_ffff);
        run_random(320, 5000, $urandom, 1'b1);
        settle();

        // --- random config, second long hold ---
        rnd_gap = $urandom_range(0, 3000);
        rnd_age = $urandom_range(0, 20000);
        write_reg(psrlt_pkg::CFG_MIN_INTERVAL, rnd_gap);
        write_reg(psrlt_pkg::CFG_ENTRY_TIMEOUT, rnd_age);
        hold_len = 300;
        run_random(320, 2000, $urandom, 1'b1);
        settle();

        // --- back to defaults, no idling at all ---
        write_reg(psrlt_pkg::CFG_MIN_INTERVAL, psrlt_pkg::MIN_INTERVAL_RST);
        write_reg(psrlt_pkg::CFG_ENTRY_TIMEOUT, psrlt_pkg::ENTRY_TIMEOUT_RST);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(320, 1500, $urandom, 1'b0);
        settle();

        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial
    begin : watchdog
        #6000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
